// ===== design/crpb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cylindrical radial pressure binning unit.
// Holds the sizing constants, codes, state type, control struct and bin struct used by all modules.
package crpb_pkg;

    // Grid limits.
    localparam int MAX_GRID_XY = 64;
    localparam int MAX_LAYERS  = 64;

    // Field widths.
    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int PRESS_W = 32;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 13;
    localparam int OUT_W   = PRESS_W;

    localparam int GRID_RESET = 64;

    // Bin store sizing.
    localparam int NBINS = MAX_LAYERS * MAX_GRID_XY;
    localparam int IDX_W = (NBINS > 1) ? $clog2(NBINS) : 1;

    // Geometry widths.
    localparam int SZ_W   = $clog2(MAX_GRID_XY + 1);
    localparam int EFF_W  = (CFG_W > SZ_W) ? CFG_W : SZ_W;
    localparam int CMP_W  = (COORD_W > SZ_W) ? COORD_W : SZ_W;
    localparam int DIFF_W = CMP_W + 1;
    localparam int R2_W   = 2 * CMP_W + 1;
    localparam int SQ_W   = ((R2_W + 3) / 2) * 2;
    localparam int ROOT_W = SQ_W / 2;

    // Divider widths.
    localparam int NUM_W = SUM_W + 2;
    localparam int DEN_W = CNT_W + 1;

    // Request codes.
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_IDX_GRID_X = 1'b0;
    localparam logic CFG_IDX_GRID_Y = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SQRT,
        ST_RD,
        ST_UPD,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic sqrt_start;
        logic div_start;
        logic mem_re;
        logic mem_we;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic [SUM_W-1:0] lateral;
        logic [SUM_W-1:0] normal;
        logic [CNT_W-1:0] count;
    } t_bin;

endpackage

// ===== design/crpb_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root: one result bit per cycle.
// Depends on crpb_pkg for the operand and root widths.
module crpb_isqrt import crpb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;
    logic            fits;

    assign trial = r_res + r_bit;
    assign fits  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Starting from the top even bit is safe: steps above the operand leave the root at zero.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ===== design/crpb_div.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, restoring, one quotient bit per cycle.
// Truncates toward zero and saturates to the output width; depends on crpb_pkg.
module crpb_div import crpb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] NEG_LIM = {{(NUM_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] Q_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] Q_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

    logic              r_abs;
    logic              r_busy;
    logic              r_sat;
    logic              r_done;
    logic              r_neg;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic [OUT_W-1:0]  r_quot;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [OUT_W-1:0]  sat_q;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        if (!r_neg) begin
            sat_q = (r_quo > POS_LIM) ? Q_MAX : r_quo[OUT_W-1:0];
        end else begin
            sat_q = (r_quo > NEG_LIM) ? Q_MIN : (~r_quo[OUT_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs  <= 1'b0;
            r_busy <= 1'b0;
            r_sat  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_abs  <= i_start;
            if (r_abs) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(1))) begin
                r_busy <= 1'b0;
                r_sat  <= 1'b1;
            end
            if (r_sat) begin
                r_sat  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The dividend register shifts out magnitude bits while quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_neg <= i_num[NUM_W-1];
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_abs) begin
            r_quo  <= r_neg ? (~r_quo + 1'b1) : r_quo;
            r_step <= STEP_W'(NUM_W);
        end else if (r_busy) begin
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo  <= {r_quo[NUM_W-2:0], fits};
            r_step <= r_step - 1'b1;
        end
        if (r_sat) begin
            r_quot <= sat_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/cylindrical_radial_pressure_binning_unit.sv =====
`timescale 1ns / 1ps
// Cylindrical radial pressure binning unit: sequencer, bin store and update datapath.
// Depends on crpb_pkg, crpb_isqrt and crpb_div.
//
// Each accumulate transfer bins one voxel into the half-voxel shell floor(2*r) of its z layer,
// adding Pxx+Pyy and Pzz to saturating 48-bit sums and bumping the bin count; each read
// transfer returns (lateral/2 - normal)/count for one bin, with its count. Items are worked
// one at a time and the input is stalled meanwhile. An accumulate spends most of its time in the
// iterative square root (one root bit per cycle, 9 bits); a read spends most of its time in the
// bit-per-cycle divider over the 50-bit numerator. After reset the bin store is cleared one
// entry per cycle, so the input stays stalled until all MAX_LAYERS * MAX_GRID_XY entries (4096)
// are cleared; configuration writes are taken throughout. A finished result
// waits in the output register, and the next item may be taken while it does.
module cylindrical_radial_pressure_binning_unit import crpb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration port.
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [COORD_W-1:0]        i_voxel_x,
    input  logic [COORD_W-1:0]        i_voxel_y,
    input  logic [COORD_W-1:0]        i_layer_z,
    input  logic [COORD_W-1:0]        i_shell_index,
    input  logic signed [PRESS_W-1:0] i_press_xx,
    input  logic signed [PRESS_W-1:0] i_press_yy,
    input  logic signed [PRESS_W-1:0] i_press_zz,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_was_binned,
    output logic signed [OUT_W-1:0]   o_profile_value,
    output logic [CNT_W-1:0]          o_bin_count
);

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    logic [IDX_W-1:0] r_clr_addr;
    logic [CFG_W-1:0] r_grid_x;
    logic [CFG_W-1:0] r_grid_y;

    // Captured request.
    logic                      r_req;
    logic [COORD_W-1:0]        r_vx;
    logic [COORD_W-1:0]        r_vy;
    logic [COORD_W-1:0]        r_lz;
    logic [COORD_W-1:0]        r_sh;
    logic signed [PRESS_W:0]   r_lat_add;
    logic signed [PRESS_W-1:0] r_pzz;

    // Geometry results.
    logic             r_ok;
    logic [R2_W-1:0]  r_r2;
    logic [R2_W-1:0]  r_hx2;
    logic [R2_W-1:0]  r_hy2;
    logic [IDX_W-1:0] r_idx;

    // Bin store.
    t_bin r_mem [NBINS];
    t_bin r_rd_data;
    t_bin upd_entry;
    t_bin mem_wdata;
    logic [IDX_W-1:0] mem_waddr;

    // Result being built and output register.
    logic             r_res_binned;
    logic [OUT_W-1:0] r_res_value;
    logic [CNT_W-1:0] r_res_count;
    logic             r_out_valid;
    logic             r_out_binned;
    logic [OUT_W-1:0] r_out_value;
    logic [CNT_W-1:0] r_out_count;

    // Combinational geometry.
    logic [SZ_W-1:0]          sx;
    logic [SZ_W-1:0]          sy;
    logic [SZ_W-1:0]          hx;
    logic [SZ_W-1:0]          hy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [R2_W-1:0]   dxe;
    logic signed [R2_W-1:0]   dye;
    logic [R2_W-1:0]          r2;
    logic                     prep_ok;
    logic [IDX_W-1:0]         idx_read;
    logic [IDX_W-1:0]         idx_acc;
    logic                     chk_pass;
    logic                     shell_ok;

    // Shared units.
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic signed [NUM_W-1:0] num;
    logic                    div_done;
    logic signed [OUT_W-1:0] div_quot;

    logic signed [SUM_W:0] lat_sum;
    logic signed [SUM_W:0] nrm_sum;

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [EFF_W-1:0] e;
        e = EFF_W'(s);
        if (e == '0) begin
            e = EFF_W'(1);
        end else if (e > EFF_W'(MAX_GRID_XY)) begin
            e = EFF_W'(MAX_GRID_XY);
        end
        return e[SZ_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] s);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    // ---------------------------------------------------------------- geometry
    assign sx  = eff_size(r_grid_x);
    assign sy  = eff_size(r_grid_y);
    assign hx  = sx - (sx >> 1);
    assign hy  = sy - (sy >> 1);
    assign dx  = $signed({1'b0, CMP_W'(r_vx)}) - $signed({1'b0, CMP_W'(sx >> 1)});
    assign dy  = $signed({1'b0, CMP_W'(r_vy)}) - $signed({1'b0, CMP_W'(sy >> 1)});
    assign dxe = R2_W'(dx);
    assign dye = R2_W'(dy);
    assign r2  = (dxe * dxe) + (dye * dye);

    always_comb begin
        if (r_req == REQ_ACCUM) begin
            prep_ok = (CMP_W'(r_vx) < CMP_W'(sx)) && (CMP_W'(r_vy) < CMP_W'(sy)) &&
                      (32'(r_lz) < 32'(MAX_LAYERS));
        end else begin
            prep_ok = (32'(r_lz) < 32'(MAX_LAYERS)) && (32'(r_sh) < 32'(MAX_GRID_XY));
        end
    end

    assign idx_read = IDX_W'(32'(r_lz) * 32'(MAX_GRID_XY) + 32'(r_sh));
    assign idx_acc  = IDX_W'(32'(r_lz) * 32'(MAX_GRID_XY) + 32'(sq_root));
    assign chk_pass = r_ok && (r_r2 <= r_hx2) && (r_r2 <= r_hy2);
    assign shell_ok = (32'(sq_root) < 32'(sx)) && (32'(sq_root) < 32'(MAX_GRID_XY));

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(NBINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_req == REQ_ACCUM) begin
                    n_state = chk_pass ? ST_SQRT : ST_DONE;
                end else begin
                    n_state = r_ok ? ST_RD : ST_DONE;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    n_state = shell_ok ? ST_RD : ST_DONE;
                end
            end
            ST_RD: begin
                n_state = (r_req == REQ_ACCUM) ? ST_UPD : ST_NUM;
            end
            ST_UPD: begin
                n_state = ST_DONE;
            end
            ST_NUM: begin
                n_state = (r_rd_data.count == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl            = '0;
        ctrl.accept     = (r_state == ST_IDLE) && i_in_valid;
        ctrl.sqrt_start = (r_state == ST_CHECK) && (r_req == REQ_ACCUM) && chk_pass;
        ctrl.mem_re     = (r_state == ST_RD);
        ctrl.mem_we     = (r_state == ST_CLEAR) || (r_state == ST_UPD);
        ctrl.div_start  = (r_state == ST_NUM) && (r_rd_data.count != '0);
        ctrl.out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_grid_x    <= CFG_W'(GRID_RESET);
            r_grid_y    <= CFG_W'(GRID_RESET);
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_GRID_X: r_grid_x <= i_cfg_data;
                    CFG_IDX_GRID_Y: r_grid_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_req        <= i_req_type;
            r_vx         <= i_voxel_x;
            r_vy         <= i_voxel_y;
            r_lz         <= i_layer_z;
            r_sh         <= i_shell_index;
            r_lat_add    <= (PRESS_W+1)'(i_press_xx) + (PRESS_W+1)'(i_press_yy);
            r_pzz        <= i_press_zz;
            r_res_binned <= 1'b0;
            r_res_value  <= '0;
            r_res_count  <= '0;
        end
        if (r_state == ST_PREP) begin
            r_ok  <= prep_ok;
            r_r2  <= r2;
            r_hx2 <= R2_W'(hx) * R2_W'(hx);
            r_hy2 <= R2_W'(hy) * R2_W'(hy);
            r_idx <= idx_read;
        end
        if ((r_state == ST_SQRT) && sq_done) begin
            r_idx <= idx_acc;
        end
        if (r_state == ST_UPD) begin
            r_res_binned <= 1'b1;
        end
        if (r_state == ST_NUM) begin
            r_res_count <= r_rd_data.count;
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_res_value <= div_quot;
        end
        if (ctrl.out_load) begin
            r_out_binned <= r_res_binned;
            r_out_value  <= r_res_value;
            r_out_count  <= r_res_count;
        end
    end

    // Read-modify-write of one bin; sums saturate, the count sticks at its maximum.
    assign lat_sum = (SUM_W+1)'($signed(r_rd_data.lateral)) + (SUM_W+1)'(r_lat_add);
    assign nrm_sum = (SUM_W+1)'($signed(r_rd_data.normal)) + (SUM_W+1)'(r_pzz);

    always_comb begin
        upd_entry.lateral = sat_sum(lat_sum);
        upd_entry.normal  = sat_sum(nrm_sum);
        upd_entry.count   = (r_rd_data.count == {CNT_W{1'b1}}) ? r_rd_data.count
                                                               : r_rd_data.count + 1'b1;
    end

    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_idx;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : upd_entry;

    always_ff @(posedge i_clk) begin
        if (ctrl.mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.mem_re) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign num = NUM_W'($signed(r_rd_data.lateral)) - (NUM_W'($signed(r_rd_data.normal)) <<< 1);

    crpb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.sqrt_start),
        .i_value (SQ_W'({r_r2, 2'b00})),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    crpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.div_start),
        .i_num   (num),
        .i_den   ({r_rd_data.count, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid     = r_out_valid;
    assign o_was_binned    = r_out_binned;
    assign o_profile_value = r_out_value;
    assign o_bin_count     = r_out_count;

    // ---------------------------------------------------------------- assertions
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQRT))
        else $error("square root finished outside its wait state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("division finished outside its wait state");

    a_binned_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_binned) |-> ((o_bin_count == '0) && (o_profile_value == '0)))
        else $error("accumulate result carries read fields");

    a_empty_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_bin_count == '0)) |-> (o_profile_value == '0))
        else $error("empty bin returned a nonzero profile value");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cylindrical_radial_pressure_binning_unit and its predictor.
// Depends on crpb_pkg and the unit's RTL; a queue-fed driver and a monitor run on both edges.
module tb_top;
    import crpb_pkg::*;

    typedef struct packed {
        logic                      req;
        logic [COORD_W-1:0]        vx;
        logic [COORD_W-1:0]        vy;
        logic [COORD_W-1:0]        lz;
        logic [COORD_W-1:0]        sh;
        logic signed [PRESS_W-1:0] pxx;
        logic signed [PRESS_W-1:0] pyy;
        logic signed [PRESS_W-1:0] pzz;
    } voxel_req_t;

    typedef struct packed {
        logic                    binned;
        logic signed [OUT_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } profile_res_t;

    localparam longint SUM_HI      = 64'sd140737488355327;
    localparam longint SUM_LO      = -64'sd140737488355328;
    localparam int     COUNT_CAP   = (1 << CNT_W) - 1;
    localparam int     HOLD_CYCLES = 400;
    localparam int     TAIL_CYCLES = 200;
    localparam int     SAT_ITEMS   = 100;
    localparam int     SAT_LAYER   = 10;
    localparam int     PHASE_ITEMS = 170;
    localparam logic [PRESS_W-1:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [PRESS_W-1:0] PMIN = 32'h8000_0000;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_we   = 1'b0;
    logic               cfg_idx  = CFG_IDX_GRID_X;
    logic [CFG_W-1:0]   cfg_data = '0;

    logic                      in_valid = 1'b0;
    logic                      in_req   = REQ_ACCUM;
    logic [COORD_W-1:0]        in_vx    = '0;
    logic [COORD_W-1:0]        in_vy    = '0;
    logic [COORD_W-1:0]        in_lz    = '0;
    logic [COORD_W-1:0]        in_sh    = '0;
    logic signed [PRESS_W-1:0] in_pxx   = '0;
    logic signed [PRESS_W-1:0] in_pyy   = '0;
    logic signed [PRESS_W-1:0] in_pzz   = '0;
    logic                      out_stall = 1'b0;

    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_was_binned;
    logic signed [OUT_W-1:0]   o_profile_value;
    logic [CNT_W-1:0]          o_bin_count;

    cylindrical_radial_pressure_binning_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (in_req),
        .i_voxel_x       (in_vx),
        .i_voxel_y       (in_vy),
        .i_layer_z       (in_lz),
        .i_shell_index   (in_sh),
        .i_press_xx      (in_pxx),
        .i_press_yy      (in_pyy),
        .i_press_zz      (in_pzz),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_was_binned    (o_was_binned),
        .o_profile_value (o_profile_value),
        .o_bin_count     (o_bin_count)
    );

    // Predictor state: shadow registers and bin store.
    logic [CFG_W-1:0] grid_x_reg = CFG_W'(GRID_RESET);
    logic [CFG_W-1:0] grid_y_reg = CFG_W'(GRID_RESET);
    longint           lateral_acc [NBINS];
    longint           normal_acc  [NBINS];
    logic [CNT_W-1:0] count_acc   [NBINS];

    voxel_req_t   voxel_queue [$];
    profile_res_t pending_profiles [$];
    voxel_req_t   cur_item;
    voxel_req_t   taken_req;
    profile_res_t want;

    logic in_fire = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    logic hold_finished  = 1'b0;
    int   hold_ctr       = 0;

    int n_pushed = 0, n_accepted = 0, n_results = 0, n_reads = 0;
    int n_binned = 0, n_cfg_writes = 0, n_errors = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic int unsigned grid_extent(input logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_GRID_XY) return MAX_GRID_XY;
        return v;
    endfunction

    function automatic longint sat_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    // Bins one voxel or reads one bin, updating the predictor's store.
    function automatic profile_res_t shell_profile_step(input voxel_req_t r);
        profile_res_t res;
        int unsigned  sx, sy, hx, hy, r2, root, idx;
        int           dx, dy;
        longint       num, q;
        res.binned = 1'b0;
        res.value  = '0;
        res.count  = '0;
        if (r.req == REQ_ACCUM) begin
            sx = grid_extent(grid_x_reg);
            sy = grid_extent(grid_y_reg);
            if (r.vx < sx && r.vy < sy && r.lz < MAX_LAYERS) begin
                dx = int'(r.vx) - int'(sx / 2);
                dy = int'(r.vy) - int'(sy / 2);
                r2 = dx * dx + dy * dy;
                hx = sx - sx / 2;
                hy = sy - sy / 2;
                if (r2 <= hx * hx && r2 <= hy * hy) begin
                    // Shell is floor(2*r), the integer root of 4*r^2.
                    root = 0;
                    while ((root + 1) * (root + 1) <= 4 * r2) root++;
                    if (root < sx && root < MAX_GRID_XY) begin
                        idx = r.lz * MAX_GRID_XY + root;
                        lateral_acc[idx] = sat_sum(lateral_acc[idx],
                                                   longint'(r.pxx) + longint'(r.pyy));
                        normal_acc[idx] = sat_sum(normal_acc[idx], longint'(r.pzz));
                        if (count_acc[idx] < COUNT_CAP) count_acc[idx] = count_acc[idx] + 1'b1;
                        res.binned = 1'b1;
                    end
                end
            end
        end else if (r.lz < MAX_LAYERS && r.sh < MAX_GRID_XY) begin
            idx = r.lz * MAX_GRID_XY + r.sh;
            res.count = count_acc[idx];
            if (count_acc[idx] != 0) begin
                num = lateral_acc[idx] - 2 * normal_acc[idx];
                q = num / (2 * longint'(count_acc[idx]));
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                res.value = q[31:0];
            end
        end
        return res;
    endfunction

    function automatic logic [PRESS_W-1:0] rand_press();
        case ($urandom_range(7))
            0: return PMAX;
            1: return PMIN;
            2: return $urandom_range(2000) - 1000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-grid voxels on a few layers and reads of those layers; the rest is noise.
    function automatic voxel_req_t gen_item();
        voxel_req_t  r;
        int unsigned sx, sy, pick;
        sx = grid_extent(grid_x_reg);
        sy = grid_extent(grid_y_reg);
        r.req = REQ_ACCUM;
        r.vx  = COORD_W'($urandom);
        r.vy  = COORD_W'($urandom);
        r.lz  = COORD_W'($urandom);
        r.sh  = COORD_W'($urandom);
        r.pxx = rand_press();
        r.pyy = rand_press();
        r.pzz = rand_press();
        pick = $urandom_range(99);
        if (pick < 70) begin
            r.vx = COORD_W'($urandom_range(sx - 1));
            r.vy = COORD_W'($urandom_range(sy - 1));
            r.lz = COORD_W'($urandom_range(3));
        end else if (pick < 90) begin
            r.req = REQ_READ;
            r.lz  = COORD_W'($urandom_range(3));
            r.sh  = COORD_W'($urandom_range(sx > 63 ? 63 : sx));
        end else if (pick < 95) begin
            r.req = REQ_READ;
        end
        return r;
    endfunction

    task automatic push_req(input logic req, input int vx, input int vy, input int lz,
                            input int sh, input logic [PRESS_W-1:0] pxx,
                            input logic [PRESS_W-1:0] pyy, input logic [PRESS_W-1:0] pzz);
        voxel_req_t r;
        r.req = req;
        r.vx  = COORD_W'(vx);
        r.vy  = COORD_W'(vy);
        r.lz  = COORD_W'(lz);
        r.sh  = COORD_W'(sh);
        r.pxx = pxx;
        r.pyy = pyy;
        r.pzz = pzz;
        voxel_queue.push_back(r);
        n_pushed++;
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_IDX_GRID_X) grid_x_reg = val;
        else grid_y_reg = val;
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input int gx, input int gy);
        write_reg(CFG_IDX_GRID_X, CFG_W'(gx));
        write_reg(CFG_IDX_GRID_Y, CFG_W'(gy));
    endtask

    // Counters move at the rising edge, so they are stable when read at the falling edge.
    task automatic wait_quiet();
        while (n_accepted != n_pushed || pending_profiles.size() != 0) @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
        $display("MISMATCH at result %0d: %s got %0d, wanted %0d", n_results, what, got, exp_val);
        n_errors++;
    endtask

    // Driver: a new item goes out only after the current one was transferred.
    always @(negedge i_clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (voxel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = voxel_queue.pop_front();
                in_valid <= 1'b1;
                in_req   <= cur_item.req;
                in_vx    <= cur_item.vx;
                in_vy    <= cur_item.vy;
                in_lz    <= cur_item.lz;
                in_sh    <= cur_item.sh;
                in_pxx   <= cur_item.pxx;
                in_pyy   <= cur_item.pyy;
                in_pzz   <= cur_item.pzz;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request && !hold_finished) begin
            out_stall <= 1'b1;
            if (hold_ctr == HOLD_CYCLES - 1) hold_finished <= 1'b1;
            hold_ctr <= hold_ctr + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: check the result transfer first, then predict the input transfer.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pending_profiles.size() == 0) begin
                    flag_mismatch("result with nothing pending, profile",
                                  longint'(o_profile_value), 0);
                end else begin
                    want = pending_profiles.pop_front();
                    if (o_was_binned !== want.binned)
                        flag_mismatch("was_binned", o_was_binned, want.binned);
                    if (o_profile_value !== want.value)
                        flag_mismatch("profile_value", longint'(o_profile_value),
                                      longint'(want.value));
                    if (o_bin_count !== want.count)
                        flag_mismatch("bin_count", o_bin_count, want.count);
                end
                n_results++;
            end
            if (in_valid && !o_in_stall) begin
                taken_req = '{in_req, in_vx, in_vy, in_lz, in_sh, in_pxx, in_pyy, in_pzz};
                want = shell_profile_step(taken_req);
                pending_profiles.push_back(want);
                n_accepted++;
                if (taken_req.req == REQ_READ) n_reads++;
                if (want.binned) n_binned++;
            end
        end
        in_fire <= rst_n && in_valid && !o_in_stall;
    end

    initial begin : main_seq
        int k, p;
        int gx_list [8];
        int gy_list [8];
        gx_list = '{64, 0, 127, 1, 17, 64, 2, 0};
        gy_list = '{64, 127, 0, 64, 33, 9, 1, 0};
        gx_list[7] = $urandom_range(127);
        gy_list[7] = $urandom_range(127);
        for (k = 0; k < NBINS; k++) begin
            lateral_acc[k] = 0;
            normal_acc[k]  = 0;
            count_acc[k]   = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // The unit clears its store after reset but takes register writes meanwhile.
        set_grid(64, 64);
        @(posedge i_clk);
        push_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        push_req(REQ_ACCUM, 32, 32, 0, 0, PMAX, PMAX, PMIN);
        push_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        push_req(REQ_ACCUM, 32, 32, 1, 0, PMIN, PMIN, PMAX);
        push_req(REQ_READ, 0, 0, 1, 0, 0, 0, 0);
        // Corner voxel lies past the half-extent; edge voxel maps to shell 64, past the last shell, and is not binned.
        push_req(REQ_ACCUM, 0, 0, 63, 63, PMAX, PMAX, PMAX);
        push_req(REQ_ACCUM, 0, 32, 63, 0, PMAX, PMAX, PMAX);
        push_req(REQ_ACCUM, 63, 32, 2, 0, 32'd123456, 32'hFFFF_0000, 32'd77);
        push_req(REQ_ACCUM, 33, 32, 2, 0, 32'd1000, -32'sd1000, 32'd7);
        push_req(REQ_ACCUM, 32, 33, 2, 0, -32'sd3, 32'd5, 32'd9);
        push_req(REQ_READ, 0, 0, 2, 2, 0, 0, 0);
        push_req(REQ_READ, 0, 0, 2, 62, 0, 0, 0);
        push_req(REQ_READ, 63, 63, 63, 63, PMAX, PMAX, PMAX);
        push_req(REQ_ACCUM, 63, 63, 63, 63, PMAX, PMAX, PMAX);
        wait_quiet();

        // A zero size counts as one voxel and an oversized one as the maximum.
        set_grid(0, 127);
        @(posedge i_clk);
        push_req(REQ_ACCUM, 0, 0, 4, 0, 32'd10, 32'd20, 32'd30);
        push_req(REQ_ACCUM, 0, 32, 4, 0, 32'd10, 32'd20, 32'd30);
        push_req(REQ_ACCUM, 1, 32, 4, 0, 32'd10, 32'd20, 32'd30);
        push_req(REQ_READ, 0, 0, 4, 0, 0, 0, 0);
        wait_quiet();
        set_grid(2, 2);
        @(posedge i_clk);
        push_req(REQ_ACCUM, 0, 0, 5, 0, 32'd1, 32'd1, 32'd1);
        push_req(REQ_ACCUM, 1, 0, 5, 0, 32'd1, 32'd1, 32'd1);
        push_req(REQ_ACCUM, 1, 1, 5, 0, 32'd8, 32'd9, -32'sd4);
        push_req(REQ_READ, 0, 0, 5, 0, 0, 0, 0);
        wait_quiet();

        // One bin fed a run of extreme pressures, read back along the way.
        set_grid(64, 64);
        @(posedge i_clk);
        for (k = 0; k < SAT_ITEMS; k++) begin
            push_req(REQ_ACCUM, 32, 32, SAT_LAYER, 0, PMAX, PMAX, PMIN);
            if (k % 32 == 31) push_req(REQ_READ, 0, 0, SAT_LAYER, 0, 0, 0, 0);
        end
        push_req(REQ_READ, 0, 0, SAT_LAYER, 0, 0, 0, 0);
        wait_quiet();

        for (p = 0; p < 8; p++) begin
            set_grid(gx_list[p], gy_list[p]);
            @(posedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) voxel_queue.push_back(gen_item());
            n_pushed += PHASE_ITEMS;
            wait_quiet();
        end

        // Receiver holds off while the sender keeps offering, so the input backs up.
        set_grid(64, 64);
        @(posedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (k = 0; k < 40; k++) voxel_queue.push_back(gen_item());
        n_pushed += 40;
        hold_request = 1'b1;
        while (!hold_finished) @(negedge i_clk);
        wait_quiet();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_profiles.size() != 0)
            flag_mismatch("results never delivered", 0, pending_profiles.size());
        $display("Run covered %0d transfers in (%0d reads, %0d voxels binned), %0d results out,",
                 n_accepted, n_reads, n_binned, n_results);
        $display("%0d register writes across grid sizes from 0 to 127, %0d mismatches.",
                 n_cfg_writes, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timed out with %0d of %0d items transferred.", n_accepted, n_pushed);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
